// ===== src/sacl_pkg.sv =====
// Shared constants, types and helper functions for the set-associative cache.
`timescale 1ns / 1ps
package sacl_pkg;
    localparam int CACHE_BYTES_DEF = 1024;
    localparam int LINE_BYTES_DEF  = 8;
    localparam int WAYS_DEF        = 2;
    localparam int ADDR_W          = 16;
    localparam int DATA_W          = 16;
    localparam int LAT_W           = 8;
    localparam int WAY_W           = 4;
    localparam int OP_W            = 2;
    localparam logic [LAT_W-1:0] LAT_RESET = 8'd1;

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_FILL  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
        logic [WAY_W-1:0]  rnd;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] rdata;
        logic [LAT_W-1:0]  lat;
        logic [WAY_W-1:0]  way;
    } t_rsp;

    function automatic int clog2i(input int n);
        int b;
        b = 0;
        while (b < 31 && (1 << b) < n) b++;
        return b;
    endfunction

    function automatic int maxi(input int a, input int b);
        return (a > b) ? a : b;
    endfunction
endpackage

// ===== src/sacl_front.sv =====
// Front end: input queue interface and a two-entry request queue.
`timescale 1ns / 1ps
module sacl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  sacl_pkg::t_req i_req,
    output logic          o_req_valid,
    input  logic          i_req_take,
    output sacl_pkg::t_req o_req
);
    import sacl_pkg::*;

    t_req     r_q [2];
    logic     r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic     w_push, w_take;

    assign o_full      = (r_cnt == 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign w_push      = i_push && !o_full;
    assign w_take      = i_req_take && o_req_valid;

    always_comb begin
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ w_take;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_q[r_wp] <= i_req;
        end
    end
endmodule

// ===== src/sacl_back.sv =====
// Back end: tag/data lookup, fill sequencing and the result register.
`timescale 1ns / 1ps
module sacl_back #(
    parameter int CACHE_BYTES = sacl_pkg::CACHE_BYTES_DEF,
    parameter int LINE_BYTES  = sacl_pkg::LINE_BYTES_DEF,
    parameter int WAYS        = sacl_pkg::WAYS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  sacl_pkg::t_req              i_req,
    output logic                        o_req_take,
    input  logic [sacl_pkg::LAT_W-1:0]  i_lat,
    output logic                        o_empty,
    input  logic                        i_pop,
    output sacl_pkg::t_rsp              o_rsp
);
    import sacl_pkg::*;

    localparam int NLINES = maxi(CACHE_BYTES / LINE_BYTES, 1);
    localparam int NSETS  = maxi(NLINES / WAYS, 1);
    localparam int WORDS  = maxi(LINE_BYTES / 2, 1);
    localparam int OB     = clog2i(LINE_BYTES);
    localparam int IB     = clog2i(NSETS);
    localparam int WB     = maxi(clog2i(WORDS), 1);
    localparam int LB     = maxi(clog2i(NLINES), 1);
    localparam int SB     = maxi(IB, 1);
    localparam int TB     = (OB + IB < ADDR_W) ? ADDR_W - OB - IB : 1;
    localparam int WYB    = maxi(clog2i(WAYS), 1);
    localparam int CB     = clog2i(WORDS + 1);

    // Tag and data are read with registered outputs; the lookup is a
    // sequencer: read stores, then compare and act, then present the result.
    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_OUT} t_state;

    logic [DATA_W-1:0] r_data [NLINES*WORDS];
    logic [TB-1:0]     r_tag  [NLINES];
    logic [NLINES-1:0] r_valid;

    t_state            r_state;
    t_req              r_req;
    t_rsp              r_rsp;
    t_rsp              n_rsp;
    logic [TB-1:0]     r_tag_rd [WAYS];
    logic [DATA_W-1:0] r_data_rd [WAYS];
    logic [CB-1:0]     r_fcnt;
    logic [WYB-1:0]    r_fway;
    logic [ADDR_W-1:0] r_faddr;

    function automatic logic [SB-1:0] set_of(input logic [ADDR_W-1:0] a);
        logic [31:0] s;
        s = (32'(a) >> OB) & ((32'd1 << IB) - 32'd1);
        // The set field is below twice the set count, so one subtract folds it.
        if (s >= 32'(NSETS)) s = s - 32'(NSETS);
        return SB'(s);
    endfunction
    function automatic logic [TB-1:0] tag_of(input logic [ADDR_W-1:0] a);
        if (OB + IB >= ADDR_W) return '0;
        return TB'(32'(a) >> (OB + IB));
    endfunction
    function automatic logic [WB-1:0] word_of(input logic [ADDR_W-1:0] a);
        logic [31:0] o;
        o = (32'(a) & ((32'd1 << OB) - 32'd1)) >> 1;
        if (o >= 32'(WORDS)) o = o - 32'(WORDS);
        return WB'(o);
    endfunction
    function automatic logic [LB-1:0] line_of(input logic [SB-1:0] s, input int w);
        logic [31:0] l;
        l = 32'(s) + 32'(w) * 32'(NSETS);
        // With fewer lines than ways there is one set and the ways wrap over the lines.
        if (NLINES < WAYS) begin
            l = '0;
            for (int k = 0; k < WAYS; k++) begin
                if (w == k) l = 32'(k % NLINES);
            end
        end
        return LB'(l);
    endfunction

    logic [SB-1:0] w_set;
    logic [TB-1:0] w_tag;
    logic [WB-1:0] w_word;
    logic          w_hit;
    logic [WYB-1:0] w_hway;
    logic [WYB-1:0] w_sel;
    logic [LB-1:0] w_fline;
    logic [SB-1:0] w_fset;

    assign w_set  = set_of(r_req.addr);
    assign w_tag  = tag_of(r_req.addr);
    assign w_word = word_of(r_req.addr);

    always_comb begin
        w_hit  = 1'b0;
        w_hway = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_valid[line_of(w_set, w)] && r_tag_rd[w] == w_tag) begin
                w_hit  = 1'b1;
                w_hway = WYB'(w);
            end
        end
        w_sel = '0;
        for (int k = 0; k < 2**WAY_W; k++) begin
            if (r_req.rnd == WAY_W'(k)) w_sel = WYB'(k % WAYS);
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!r_valid[line_of(w_set, w)]) w_sel = WYB'(w);
        end
        n_rsp = '0;
        if (r_req.op == OP_READ || r_req.op == OP_WRITE) begin
            if (w_hit) begin
                n_rsp.hit = 1'b1;
                n_rsp.lat = i_lat;
                n_rsp.way = WAY_W'(w_hway);
                if (r_req.op == OP_READ) n_rsp.rdata = r_data_rd[w_hway];
            end
        end else if (r_req.op == OP_FILL) begin
            n_rsp.way = WAY_W'((r_fcnt == '0) ? w_sel : r_fway);
        end
    end

    assign w_fset  = (r_fcnt == '0) ? w_set : set_of(r_faddr);
    assign w_fline = line_of(w_fset, (r_fcnt == '0) ? int'(w_sel) : int'(r_fway));

    assign o_req_take = (r_state == S_IDLE) && i_req_valid;
    assign o_empty    = (r_state != S_OUT);
    assign o_rsp      = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_fcnt  <= '0;
            r_fway  <= '0;
            r_faddr <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) r_state <= S_LOOK;
                end
                S_LOOK: begin
                    r_state <= S_OUT;
                    r_rsp   <= n_rsp;
                    if (r_req.op == OP_FILL) begin
                        if (r_fcnt == '0) begin
                            r_faddr <= r_req.addr;
                            r_fway  <= w_sel;
                        end
                        if (r_fcnt == CB'(WORDS - 1)) begin
                            r_fcnt           <= '0;
                            r_valid[w_fline] <= 1'b1;
                        end else begin
                            r_fcnt           <= r_fcnt + 1'b1;
                            r_valid[w_fline] <= 1'b0;
                        end
                    end
                end
                S_OUT: begin
                    if (i_pop) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Memories and payload registers.
    always_ff @(posedge i_clk) begin
        if (o_req_take) begin
            r_req <= i_req;
            for (int w = 0; w < WAYS; w++) begin
                r_tag_rd[w]  <= r_tag[line_of(set_of(i_req.addr), w)];
                r_data_rd[w] <= r_data[32'(line_of(set_of(i_req.addr), w)) * WORDS
                                       + 32'(word_of(i_req.addr))];
            end
        end
        if (r_state == S_LOOK) begin
            if (r_req.op == OP_WRITE && w_hit) begin
                r_data[32'(line_of(w_set, int'(w_hway))) * WORDS + 32'(w_word)]
                    <= r_req.wdata;
            end else if (r_req.op == OP_FILL) begin
                r_data[32'(w_fline) * WORDS + 32'(r_fcnt)] <= r_req.wdata;
                if (r_fcnt == CB'(WORDS - 1)) begin
                    r_tag[w_fline] <= (r_fcnt == '0) ? w_tag : tag_of(r_faddr);
                end
            end
        end
    end
endmodule

// ===== src/set_assoc_cache_lookup_fill.sv =====
// Top level of the set-associative cache with line fill.
`timescale 1ns / 1ps
// Set-associative cache of 16-bit words with random replacement. Requests
// enter through a two-deep queue (push/full) and results leave through
// empty/pop, one result per request in order. The back end handles one
// request at a time: it reads the tag and data memories into registers,
// then compares and updates, then holds the result until it is popped;
// it takes no new request before the pop. A fill line arrives as
// LINE_BYTES/2 fill requests; the tag is written and the line made valid on
// the last word. access_latency is written through cfg_valid/cfg_ready.
module set_assoc_cache_lookup_fill #(
    parameter int CACHE_BYTES = sacl_pkg::CACHE_BYTES_DEF,
    parameter int LINE_BYTES  = sacl_pkg::LINE_BYTES_DEF,
    parameter int WAYS        = sacl_pkg::WAYS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [sacl_pkg::OP_W-1:0]     i_operation,
    input  logic [sacl_pkg::ADDR_W-1:0]   i_address,
    input  logic [sacl_pkg::DATA_W-1:0]   i_write_data,
    input  logic [sacl_pkg::WAY_W-1:0]    i_random_way,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_hit,
    output logic [sacl_pkg::DATA_W-1:0]   o_read_data,
    output logic [sacl_pkg::LAT_W-1:0]    o_latency,
    output logic [sacl_pkg::WAY_W-1:0]    o_way,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sacl_pkg::LAT_W-1:0]    i_cfg_data
);
    import sacl_pkg::*;

    t_req             w_in, w_req;
    t_rsp             w_rsp;
    logic             w_req_valid, w_req_take;
    logic [LAT_W-1:0] r_lat;

    assign w_in = '{op: i_operation, addr: i_address, wdata: i_write_data,
                    rnd: i_random_way};
    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat <= LAT_RESET;
        end else if (cfg_valid) begin
            r_lat <= i_cfg_data;
        end
    end

    sacl_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_req(w_in),
        .o_req_valid(w_req_valid), .i_req_take(w_req_take), .o_req(w_req)
    );

    sacl_back #(.CACHE_BYTES(CACHE_BYTES), .LINE_BYTES(LINE_BYTES), .WAYS(WAYS)) u_back (
        .i_clk, .i_rst_n, .i_req_valid(w_req_valid), .i_req(w_req),
        .o_req_take(w_req_take), .i_lat(r_lat), .o_empty(empty), .i_pop(pop),
        .o_rsp(w_rsp)
    );

    assign o_hit       = w_rsp.hit;
    assign o_read_data = w_rsp.rdata;
    assign o_latency   = w_rsp.lat;
    assign o_way       = w_rsp.way;
endmodule

// ===== src/sacl_checker.sv =====
// Port-level checks for the cache, bound to the top level.
`timescale 1ns / 1ps
module sacl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic       o_hit,
    input logic [15:0] o_read_data,
    input logic [7:0] o_latency,
    input logic [3:0] o_way
);
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_hit) |-> (o_latency == 8'd0 && o_read_data == 16'd0))
        else $error("miss result carries nonzero data or latency");
    a_hit_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_hit) |-> (o_latency != 8'd0))
        else $error("hit with zero latency");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_way) && $stable(o_hit)))
        else $error("waiting result changed");
    a_one_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop) |=> empty)
        else $error("result repeated after pop");
endmodule

bind set_assoc_cache_lookup_fill sacl_checker u_sacl_checker (
    .i_clk, .i_rst_n, .empty, .pop, .o_hit, .o_read_data, .o_latency, .o_way
);
